// File: rtl/core/i85alu_pkg.sv
// ----------------------------------------------------------------------------
// i85alu_pkg
// Shared types and constants of the 8085-style ALU: the action codes, the
// flag bit positions and the kept architectural state.
// ----------------------------------------------------------------------------
package i85alu_pkg;

    typedef enum logic [4:0] {
        ACT_ADD  = 5'd0,
        ACT_ADC  = 5'd1,
        ACT_SUB  = 5'd2,
        ACT_SBB  = 5'd3,
        ACT_CMP  = 5'd4,
        ACT_DAD  = 5'd5,
        ACT_INR  = 5'd6,
        ACT_DCR  = 5'd7,
        ACT_INX  = 5'd8,
        ACT_DCX  = 5'd9,
        ACT_AND  = 5'd10,
        ACT_OR   = 5'd11,
        ACT_XOR  = 5'd12,
        ACT_RLC  = 5'd13,
        ACT_RRC  = 5'd14,
        ACT_RAL  = 5'd15,
        ACT_RAR  = 5'd16,
        ACT_DAA  = 5'd17,
        ACT_CMA  = 5'd18,
        ACT_CMC  = 5'd19,
        ACT_STC  = 5'd20,
        ACT_LOAD = 5'd21
    } t_action;

    // Bit positions within the flag byte.
    localparam int unsigned FLAG_S    = 7;
    localparam int unsigned FLAG_Z    = 6;
    localparam int unsigned FLAG_X    = 5;
    localparam int unsigned FLAG_A    = 4;
    localparam int unsigned FLAG_RSVD = 3;
    localparam int unsigned FLAG_P    = 2;
    localparam int unsigned FLAG_V    = 1;
    localparam int unsigned FLAG_C    = 0;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] hl;
    } t_arch;

endpackage

// File: rtl/core/i85alu_exec.sv
// ----------------------------------------------------------------------------
// i85alu_exec
// Combinational execute stage: forms the next accumulator, flag byte and HL
// pair, and the side result, from the current state and one item.
// ----------------------------------------------------------------------------
module i85alu_exec (
    input  logic [4:0]          i_action,
    input  logic [7:0]          i_operand8,
    input  logic [15:0]         i_operand16,
    input  logic [7:0]          i_flags_in,
    input  i85alu_pkg::t_arch   i_state,
    output i85alu_pkg::t_arch   o_state,
    output logic [15:0]         o_value
);
    import i85alu_pkg::*;

    // Sign, zero, bit-5 and even-parity flags of an 8-bit result.
    function automatic logic [7:0] szxp(input logic [7:0] r);
        logic [7:0] f;
        f         = 8'h00;
        f[FLAG_S] = r[7];
        f[FLAG_Z] = (r == 8'h00);
        f[FLAG_X] = r[5];
        f[FLAG_P] = ~^r;
        return f;
    endfunction

    t_action     act;
    logic [7:0]  acc;
    logic [7:0]  flg;
    logic        cf;
    logic [7:0]  kept;

    // Shared adder, also used by decimal adjust.
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  corr;
    logic [7:0]  add_b;
    logic        add_cin;
    logic [8:0]  sum9;
    logic [4:0]  sum_lo;
    logic [7:0]  add_f;

    // Subtractor, shared by sub, sbb and cmp.
    logic        sub_cin;
    logic [8:0]  sub_t;
    logic [7:0]  sub_res;
    logic [7:0]  sub_f;

    logic [7:0]  inc_res;
    logic [7:0]  dec_res;
    logic [7:0]  incdec_f;
    logic [16:0] dad_sum;

    assign act  = t_action'(i_action);
    assign acc  = i_state.acc;
    assign flg  = i_state.flags;
    assign cf   = flg[FLAG_C];

    always_comb begin
        kept            = 8'h00;
        kept[FLAG_RSVD] = flg[FLAG_RSVD];
    end

    assign daa_lo  = (acc[3:0] > 4'd9) || flg[FLAG_A];
    assign daa_hi  = (acc > 8'h99) || cf;
    assign corr    = {1'b0, daa_hi, daa_hi, 1'b0, 1'b0, daa_lo, daa_lo, 1'b0};
    assign add_b   = (act == ACT_DAA) ? corr : i_operand8;
    assign add_cin = (act == ACT_ADC) && cf;
    assign sum9    = {1'b0, acc} + {1'b0, add_b} + {8'h00, add_cin};
    assign sum_lo  = {1'b0, acc[3:0]} + {1'b0, add_b[3:0]} + {4'h0, add_cin};

    always_comb begin
        add_f         = kept | szxp(sum9[7:0]);
        add_f[FLAG_A] = sum_lo[4];
        add_f[FLAG_V] = ~(acc[7] ^ add_b[7]) & (acc[7] ^ sum9[7]);
        // Decimal adjust reports its own carry rather than the adder's.
        add_f[FLAG_C] = (act == ACT_DAA) ? daa_hi : sum9[8];
    end

    assign sub_cin = (act == ACT_SBB) && cf;
    assign sub_t   = {1'b0, i_operand8} + {8'h00, sub_cin};
    assign sub_res = acc - sub_t[7:0];

    always_comb begin
        sub_f         = kept | szxp(sub_res);
        sub_f[FLAG_C] = ({1'b0, acc} < sub_t);
        sub_f[FLAG_A] = ({1'b0, acc[3:0]} >= ({1'b0, i_operand8[3:0]} + {4'h0, sub_cin}));
        sub_f[FLAG_V] = (acc[7] ^ i_operand8[7]) & (acc[7] ^ sub_res[7]);
    end

    assign inc_res = i_operand8 + 8'd1;
    assign dec_res = i_operand8 - 8'd1;

    always_comb begin
        if (act == ACT_INR) begin
            incdec_f         = kept | szxp(inc_res);
            incdec_f[FLAG_A] = (i_operand8[3:0] == 4'hf);
            incdec_f[FLAG_V] = (i_operand8 == 8'h7f);
        end else begin
            incdec_f         = kept | szxp(dec_res);
            incdec_f[FLAG_A] = (i_operand8[3:0] != 4'h0);
            incdec_f[FLAG_V] = (i_operand8 == 8'h80);
        end
        incdec_f[FLAG_C] = cf;
    end

    assign dad_sum = {1'b0, i_state.hl} + {1'b0, i_operand16};

    always_comb begin
        o_state = i_state;
        o_value = 16'h0000;
        case (act)
            ACT_ADD, ACT_ADC, ACT_DAA: begin
                o_state.acc   = sum9[7:0];
                o_state.flags = add_f;
            end
            ACT_SUB, ACT_SBB: begin
                o_state.acc   = sub_res;
                o_state.flags = sub_f;
            end
            ACT_CMP: begin
                o_state.flags = sub_f;
            end
            ACT_DAD: begin
                o_state.hl            = dad_sum[15:0];
                o_state.flags[FLAG_C] = dad_sum[16];
                o_state.flags[FLAG_V] = ~(i_state.hl[15] ^ i_operand16[15])
                                        & (i_state.hl[15] ^ dad_sum[15]);
            end
            ACT_INR: begin
                o_state.flags = incdec_f;
                o_value       = {8'h00, inc_res};
            end
            ACT_DCR: begin
                o_state.flags = incdec_f;
                o_value       = {8'h00, dec_res};
            end
            ACT_INX: begin
                o_value = i_operand16 + 16'd1;
            end
            ACT_DCX: begin
                o_value = i_operand16 - 16'd1;
            end
            ACT_AND: begin
                o_state.acc           = acc & i_operand8;
                o_state.flags         = kept | szxp(acc & i_operand8);
                o_state.flags[FLAG_A] = 1'b1;
            end
            ACT_OR: begin
                o_state.acc   = acc | i_operand8;
                o_state.flags = kept | szxp(acc | i_operand8);
            end
            ACT_XOR: begin
                o_state.acc   = acc ^ i_operand8;
                o_state.flags = kept | szxp(acc ^ i_operand8);
            end
            ACT_RLC, ACT_RAL: begin
                o_state.acc           = {acc[6:0], (act == ACT_RLC) ? acc[7] : cf};
                o_state.flags[FLAG_C] = acc[7];
                o_state.flags[FLAG_V] = acc[7] ^ acc[6];
            end
            ACT_RRC, ACT_RAR: begin
                o_state.acc           = {(act == ACT_RRC) ? acc[0] : cf, acc[7:1]};
                o_state.flags[FLAG_C] = acc[0];
            end
            ACT_CMA: begin
                o_state.acc = ~acc;
            end
            ACT_CMC: begin
                o_state.flags[FLAG_C] = ~cf;
            end
            ACT_STC: begin
                o_state.flags[FLAG_C] = 1'b1;
            end
            ACT_LOAD: begin
                o_state.acc   = i_operand8;
                o_state.flags = i_flags_in;
                o_state.hl    = i_operand16;
            end
            default: begin
                // Unassigned codes leave the state alone.
            end
        endcase
    end

endmodule

// File: rtl/core/i8085_alu_flags_core.sv
// ----------------------------------------------------------------------------
// i8085_alu_flags_core
// 8085-style ALU with kept accumulator, flag byte and HL pair.
//
// Usage: each item on the input channel (i_in_valid / o_in_ready) carries an
// action code with its 8-bit and 16-bit operands and a flag byte for the
// load action. Every item gives exactly one result on the output channel
// (o_out_valid / i_out_ready): the accumulator, flag byte and HL pair after
// the operation, plus the side result of inr, dcr, inx and dcx.
// The result is registered: it appears in the cycle after the item is
// accepted. Throughput is one item per cycle while the receiver takes each
// result; the whole operation is one pass through the execute logic, set by
// the adder and flag logic between the state registers and themselves.
// The input is ready whenever the output register is empty or its result is
// being taken in the same cycle, so a stalled receiver holds the result and
// stops intake after exactly one buffered item.
// Reset clears the accumulator, flag byte and HL pair to zero and empties
// the output register.
// ----------------------------------------------------------------------------
module i8085_alu_flags_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [4:0]  i_action,
    input  logic [7:0]  i_operand8,
    input  logic [15:0] i_operand16,
    input  logic [7:0]  i_flags_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_flags_out,
    output logic [15:0] o_hl_out,
    output logic [15:0] o_value_out
);
    import i85alu_pkg::*;

    // Architectural state. It changes only when an item is accepted, which
    // is also the only moment the output register is loaded, so the state
    // doubles as the held result payload.
    t_arch       r_arch;
    t_arch       n_arch;
    logic [15:0] r_value;
    logic [15:0] n_value;
    logic        r_out_valid;
    logic        w_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    i85alu_exec u_exec (
        .i_action    (i_action),
        .i_operand8  (i_operand8),
        .i_operand16 (i_operand16),
        .i_flags_in  (i_flags_in),
        .i_state     (r_arch),
        .o_state     (n_arch),
        .o_value     (n_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_arch      <= n_arch;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The side result is payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= n_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_acc_out   = r_arch.acc;
    assign o_flags_out = r_arch.flags;
    assign o_hl_out    = r_arch.hl;
    assign o_value_out = r_value;

    // Every accepted item produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted item produced no result");

    // The state never moves without an accepted item.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_accept) |=> $stable(r_arch))
        else $error("state changed without an accepted item");

    // The unused flag bit only changes through the load action.
    a_rsvd_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action != ACT_LOAD))
        |=> (r_arch.flags[FLAG_RSVD] == $past(r_arch.flags[FLAG_RSVD])))
        else $error("reserved flag bit changed outside load");

    // Actions other than the increments and decrements report no side result.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action != ACT_INR) && (i_action != ACT_DCR)
         && (i_action != ACT_INX) && (i_action != ACT_DCX))
        |=> (o_value_out == 16'h0000))
        else $error("side result set by an action that has none");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of i8085_alu_flags_core
// Items are queued up front and driven at the falling edge. The block's
// outputs are sampled at the rising edge. Each accepted item runs through a
// bit-exact model of the 8085-style ALU, which keeps its own accumulator,
// flag byte and HL pair. Every accepted result is compared, field by field,
// with the oldest predicted state. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i85alu_pkg::*;

    // Chance, in percent, that a side idles in a given cycle.
    localparam int unsigned IN_IDLE_PCT     = 7;
    localparam int unsigned OUT_IDLE_PCT    = 7;
    localparam int unsigned RANDOM_ITEMS    = 1700;
    // Cycles with no accepted item or result before the run is abandoned.
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    // Settling time after the last result.
    localparam int unsigned TAIL_CYCLES     = 10;

    // Flag masks, built from the bit positions in the package.
    localparam logic [7:0] F_A     = 8'(1 << FLAG_A);
    localparam logic [7:0] F_V     = 8'(1 << FLAG_V);
    localparam logic [7:0] F_C     = 8'(1 << FLAG_C);
    // Every flag except the reserved bit 3, and the same without carry.
    localparam logic [7:0] F_ARITH = 8'hf7;
    localparam logic [7:0] F_NO_C  = 8'hf6;

    typedef struct {
        logic [4:0]  action;
        logic [7:0]  op8;
        logic [15:0] op16;
        logic [7:0]  fin;
        bit          drain;   // hold this item back until every result is in
    } t_alu_item;

    typedef struct {
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] hl;
        logic [15:0] value;
    } t_alu_state;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [4:0]  i_action    = '0;
    logic [7:0]  i_operand8  = '0;
    logic [15:0] i_operand16 = '0;
    logic [7:0]  i_flags_in  = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_acc_out;
    logic [7:0]  o_flags_out;
    logic [15:0] o_hl_out;
    logic [15:0] o_value_out;

    t_alu_item   alu_requests[$];
    t_alu_state  expected_states[$];

    // The model's copy of the architectural state.
    logic [7:0]  kept_acc;
    logic [7:0]  kept_flags;
    logic [15:0] kept_hl;

    bit          in_fire     = 1'b0;
    bit          out_fire    = 1'b0;
    bit          all_done    = 1'b0;
    bit          calm        = 1'b0;
    int unsigned sent_count  = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches  = 0;

    i8085_alu_flags_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_operand8  (i_operand8),
        .i_operand16 (i_operand16),
        .i_flags_in  (i_flags_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_acc_out   (o_acc_out),
        .o_flags_out (o_flags_out),
        .o_hl_out    (o_hl_out),
        .o_value_out (o_value_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // ALU model
    // ------------------------------------------------------------------

    // Sign, zero, bit-5 copy and even parity of an 8-bit result.
    function automatic logic [7:0] szxp_of(input logic [7:0] r);
        logic [7:0] f;
        f = 8'h00;
        f[FLAG_S] = r[7];
        f[FLAG_Z] = (r == 8'h00);
        f[FLAG_X] = r[5];
        f[FLAG_P] = ~^r;
        return f;
    endfunction

    // Addition at nine bits; carry-in is either zero or the carry flag.
    function automatic void acc_add(input logic [7:0] b, input logic c);
        logic [8:0] sum;
        logic [4:0] nib;
        logic [7:0] res;
        logic [7:0] f;
        sum = {1'b0, kept_acc} + {1'b0, b} + {8'h00, c};
        nib = {1'b0, kept_acc[3:0]} + {1'b0, b[3:0]} + {4'h0, c};
        res = sum[7:0];
        f = (kept_flags & ~F_ARITH) | szxp_of(res);
        f[FLAG_C] = sum[8];
        f[FLAG_A] = nib[4];
        f[FLAG_V] = ~(kept_acc[7] ^ b[7]) & (kept_acc[7] ^ res[7]);
        kept_acc = res;
        kept_flags = f;
    endfunction

    // Subtraction of operand plus borrow-in. The borrow is only set when the
    // whole subtrahend exceeds A, so a zero subtrahend never borrows, and an
    // operand of 0xff with carry set subtracts a full 256.
    function automatic void acc_sub(input logic [7:0] b, input logic c,
                                    input bit store);
        logic [8:0] t;
        logic [7:0] res;
        logic [7:0] f;
        t = {1'b0, b} + {8'h00, c};
        res = kept_acc - t[7:0];
        f = (kept_flags & ~F_ARITH) | szxp_of(res);
        f[FLAG_C] = ({1'b0, kept_acc} < t);
        f[FLAG_A] = ({1'b0, kept_acc[3:0]} >= ({1'b0, b[3:0]} + {4'h0, c}));
        f[FLAG_V] = (kept_acc[7] ^ b[7]) & (kept_acc[7] ^ res[7]);
        if (store) kept_acc = res;
        kept_flags = f;
    endfunction

    function automatic void acc_logic(input logic [7:0] res, input bit aux);
        kept_acc = res;
        kept_flags = (kept_flags & ~F_ARITH) | szxp_of(res) | (aux ? F_A : 8'h00);
    endfunction

    // INR and DCR leave A alone and keep carry; the result goes to value only.
    function automatic logic [7:0] step_by_one(input logic [7:0] x, input bit inc);
        logic [7:0] res;
        logic [7:0] f;
        res = inc ? x + 8'h01 : x - 8'h01;
        f = (kept_flags & ~F_NO_C) | szxp_of(res);
        if (inc) begin
            f[FLAG_A] = (x[3:0] == 4'hf);
            f[FLAG_V] = (x == 8'h7f);
        end else begin
            f[FLAG_A] = (x[3:0] != 4'h0);
            f[FLAG_V] = (x == 8'h80);
        end
        kept_flags = f;
        return res;
    endfunction

    function automatic void decimal_adjust();
        logic [7:0] corr;
        logic       cy;
        corr = 8'h00;
        cy = kept_flags[FLAG_C];
        if (kept_acc[3:0] > 4'h9 || kept_flags[FLAG_A]) corr |= 8'h06;
        if (kept_acc > 8'h99 || cy) begin
            corr |= 8'h60;
            cy = 1'b1;
        end
        acc_add(corr, 1'b0);
        kept_flags[FLAG_C] = cy;
    endfunction

    // Runs one item on the model state and returns the state it leaves.
    function automatic t_alu_state execute_alu(input t_alu_item it);
        t_alu_state st;
        logic       cf;
        logic [7:0] a;
        logic [16:0] s;
        logic [15:0] value;
        cf = kept_flags[FLAG_C];
        a = kept_acc;
        value = 16'h0000;
        case (it.action)
            ACT_ADD: acc_add(it.op8, 1'b0);
            ACT_ADC: acc_add(it.op8, cf);
            ACT_SUB: acc_sub(it.op8, 1'b0, 1'b1);
            ACT_SBB: acc_sub(it.op8, cf, 1'b1);
            ACT_CMP: acc_sub(it.op8, 1'b0, 1'b0);
            ACT_DAD: begin
                s = {1'b0, kept_hl} + {1'b0, it.op16};
                kept_flags &= ~(F_C | F_V);
                kept_flags[FLAG_C] = s[16];
                kept_flags[FLAG_V] = ~(kept_hl[15] ^ it.op16[15]) & (kept_hl[15] ^ s[15]);
                kept_hl = s[15:0];
            end
            ACT_INR: value = {8'h00, step_by_one(it.op8, 1'b1)};
            ACT_DCR: value = {8'h00, step_by_one(it.op8, 1'b0)};
            ACT_INX: value = it.op16 + 16'h0001;
            ACT_DCX: value = it.op16 - 16'h0001;
            ACT_AND: acc_logic(a & it.op8, 1'b1);
            ACT_OR:  acc_logic(a | it.op8, 1'b0);
            ACT_XOR: acc_logic(a ^ it.op8, 1'b0);
            ACT_RLC, ACT_RAL: begin
                kept_acc = {a[6:0], (it.action == ACT_RLC) ? a[7] : cf};
                kept_flags[FLAG_C] = a[7];
                kept_flags[FLAG_V] = a[7] ^ a[6];
            end
            ACT_RRC, ACT_RAR: begin
                kept_acc = {(it.action == ACT_RRC) ? a[0] : cf, a[7:1]};
                kept_flags[FLAG_C] = a[0];
            end
            ACT_DAA: decimal_adjust();
            ACT_CMA: kept_acc = ~a;
            ACT_CMC: kept_flags[FLAG_C] = ~cf;
            ACT_STC: kept_flags[FLAG_C] = 1'b1;
            ACT_LOAD: begin
                kept_acc = it.op8;
                kept_flags = it.fin;
                kept_hl = it.op16;
            end
            // The spare codes leave the state as it is.
            default: ;
        endcase
        st.acc = kept_acc;
        st.flags = kept_flags;
        st.hl = kept_hl;
        st.value = value;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_item(input logic [4:0] action, input logic [7:0] op8,
                             input logic [15:0] op16, input logic [7:0] fin);
        t_alu_item it;
        it.action = action;
        it.op8 = op8;
        it.op16 = op16;
        it.fin = fin;
        it.drain = 1'b0;
        alu_requests.push_back(it);
    endtask

    function automatic logic [7:0] random_bcd();
        return {4'($urandom_range(9)), 4'($urandom_range(9))};
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items at the falling edge. A new item is only
    // put up once the previous one has gone, so valid and payload never
    // change while an item is waiting. Between roughly items 600 and 1000
    // neither side idles at all.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : p_driver
        t_alu_item it;
        calm = (sent_count >= 600 && sent_count < 1000);
        i_out_ready <= calm || ($urandom_range(99) >= OUT_IDLE_PCT);
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (alu_requests.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (alu_requests[0].drain && expected_states.size() != 0) begin
                // Pause the sender until the pipeline has emptied.
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(99) < IN_IDLE_PCT) begin
                i_in_valid <= 1'b0;
            end else begin
                it = alu_requests.pop_front();
                i_in_valid  <= 1'b1;
                i_action    <= it.action;
                i_operand8  <= it.op8;
                i_operand16 <= it.op16;
                i_flags_in  <= it.fin;
                sent_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, checks a result being taken against the
    // oldest prediction, then predicts for an item being taken. The result
    // of an item taken at this edge can only be taken at a later one, so
    // the order of the two steps is safe.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : p_monitor
        t_alu_item  it;
        t_alu_state want;
        in_fire = 1'b0;
        out_fire = 1'b0;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            out_fire = o_out_valid && i_out_ready;
            in_fire = i_in_valid && o_in_ready;
            if (out_fire) begin
                if (expected_states.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, actual acc %h flags %h hl %h value %h",
                             $time, o_acc_out, o_flags_out, o_hl_out, o_value_out);
                end else begin
                    want = expected_states.pop_front();
                    check_field("acc_out",   {8'h00, want.acc},   {8'h00, o_acc_out});
                    check_field("flags_out", {8'h00, want.flags}, {8'h00, o_flags_out});
                    check_field("hl_out",    want.hl,             o_hl_out);
                    check_field("value_out", want.value,          o_value_out);
                end
            end
            if (in_fire) begin
                it.action = i_action;
                it.op8 = i_operand8;
                it.op16 = i_operand16;
                it.fin = i_flags_in;
                it.drain = 1'b0;
                expected_states.push_back(execute_alu(it));
            end
            if (in_fire || out_fire) idle_cycles = 0;
            else idle_cycles++;
        end
        all_done = (alu_requests.size() == 0) && !i_in_valid && !in_fire &&
                   (expected_states.size() == 0);
    end

    // Watchdog: a run that stops moving is a failure.
    initial begin : p_watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : p_main
        int unsigned n_directed;
        int unsigned pick;
        logic [4:0]  act;

        kept_acc = 8'h00;
        kept_flags = 8'h00;
        kept_hl = 16'h0000;

        // Directed part: field extremes, each action, and the corner cases.
        push_item(ACT_LOAD, 8'hff, 16'hffff, 8'hff);
        push_item(ACT_ADC,  8'hff, 16'h0000, 8'h00);  // carry in with full operand
        push_item(ACT_LOAD, 8'h00, 16'h0000, 8'h00);
        push_item(ACT_SBB,  8'h00, 16'h0000, 8'h00);  // zero subtrahend: no borrow
        push_item(ACT_LOAD, 8'h00, 16'h8000, 8'h01);
        push_item(ACT_SBB,  8'hff, 16'h0000, 8'h00);  // subtrahend of 256
        push_item(ACT_SUB,  8'h80, 16'h0000, 8'h00);
        push_item(ACT_CMP,  8'hff, 16'h0000, 8'h00);
        push_item(ACT_ADD,  8'h80, 16'h0000, 8'h00);
        push_item(ACT_DAD,  8'h00, 16'h8000, 8'h00);  // signed overflow and carry
        push_item(ACT_INR,  8'h7f, 16'h0000, 8'h00);
        push_item(ACT_INR,  8'hff, 16'h0000, 8'h00);
        push_item(ACT_DCR,  8'h80, 16'h0000, 8'h00);
        push_item(ACT_DCR,  8'h00, 16'h0000, 8'h00);
        push_item(ACT_INX,  8'h00, 16'hffff, 8'h00);
        push_item(ACT_DCX,  8'h00, 16'h0000, 8'h00);
        push_item(ACT_AND,  8'hff, 16'h0000, 8'h00);
        push_item(ACT_OR,   8'h00, 16'h0000, 8'h00);
        push_item(ACT_XOR,  8'hff, 16'h0000, 8'h00);
        push_item(ACT_RLC,  8'h00, 16'h0000, 8'h00);
        push_item(ACT_RRC,  8'h00, 16'h0000, 8'h00);
        push_item(ACT_RAL,  8'h00, 16'h0000, 8'h00);
        push_item(ACT_RAR,  8'h00, 16'h0000, 8'h00);
        push_item(ACT_LOAD, 8'h9a, 16'h0000, 8'h11);  // decimal adjust on both nibbles
        push_item(ACT_DAA,  8'h00, 16'h0000, 8'h00);
        push_item(ACT_CMA,  8'h00, 16'h0000, 8'h00);
        push_item(ACT_CMC,  8'h00, 16'h0000, 8'h00);
        push_item(ACT_STC,  8'h00, 16'h0000, 8'h00);
        push_item(5'd31,    8'h00, 16'h0000, 8'h00);  // spare code, no change
        n_directed = alu_requests.size();

        // Random part. A share of it is BCD arithmetic followed by a decimal
        // adjust, so that the adjust sees the flags it was meant for.
        while (alu_requests.size() < n_directed + RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                push_item(ACT_LOAD, random_bcd(), 16'($urandom), 8'($urandom));
                act = ($urandom_range(1) == 0) ? ACT_ADD : ACT_ADC;
                if ($urandom_range(2) == 0) act = ($urandom_range(1) == 0) ? ACT_SUB : ACT_SBB;
                push_item(act, random_bcd(), 16'($urandom), 8'($urandom));
                push_item(ACT_DAA, 8'($urandom), 16'($urandom), 8'($urandom));
            end else if (pick < 20) begin
                push_item(ACT_LOAD, 8'($urandom), 16'($urandom), 8'($urandom));
            end else if (pick < 24) begin
                push_item(5'($urandom_range(31, 22)), 8'($urandom), 16'($urandom),
                          8'($urandom));
            end else begin
                push_item(5'($urandom_range(20)), 8'($urandom), 16'($urandom),
                          8'($urandom));
            end
        end

        // The sender waits for an empty pipeline at the start of the random
        // part and once more later on.
        alu_requests[n_directed].drain = 1'b1;
        alu_requests[n_directed + 1200].drain = 1'b1;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (all_done);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_states.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/i85alu_pkg.sv
rtl/core/i85alu_exec.sv
rtl/core/i8085_alu_flags_core.sv
verif/tb.sv
